// ===== sv/sdse_pkg.sv =====
`default_nettype none
package sdse_pkg;

   localparam int STORE_DEPTH   = 32;
   localparam int MESSAGE_PAIRS = 16;
   localparam int MAX_RESULTS   = 32;

   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 5;
   localparam int CODE_W   = 8;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 6;
   localparam int NODE_W   = 16;
   localparam int ACT_W    = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int EFF_W  = (CNT_W > ACT_W) ? CNT_W : ACT_W;
   localparam int CMP_W  = 9;
   localparam int RES_W  = $clog2(MAX_RESULTS + 1);
   localparam int PAIR_W = $clog2(MESSAGE_PAIRS + 1);

   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_APPLY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESYNC = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_NODE     = 1'd1;

   localparam logic KIND_PAIR = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic take;
      logic start_scan;
      logic load_read;
      logic step;
      logic emit_mid;
      logic emit_final;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic diff;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== sv/sdse_if.sv =====
`default_nettype none
interface sdse_req_if;
   import sdse_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [INDEX_W-1:0]  index;
   logic [CODE_W-1:0]   position_code;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, cmd, index, position_code, data_byte, input ready);
   modport sink (input valid, cmd, index, position_code, data_byte, output ready);
endinterface

interface sdse_rsp_if;
   import sdse_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [POS_W-1:0]    pair_position;
   logic [BYTE_W-1:0]   pair_value;
   logic [NODE_W-1:0]   node;
   logic                message_end;
   logic                last;

   modport source (output valid, kind, pair_position, pair_value, node, message_end, last,
                   input ready);
   modport sink (input valid, kind, pair_position, pair_value, node, message_end, last,
                 output ready);
endinterface
`default_nettype wire

// ===== sv/sdse_ctrl.sv =====
`default_nettype none
module sdse_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [sdse_pkg::CMD_W-1:0]    req_cmd,
   input  sdse_pkg::dp_status_type       status,
   output logic                          req_ready,
   output sdse_pkg::ctrl_cmd_type        ctrl
);
   import sdse_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.take = 1'b1;
               if (req_cmd == CMD_READ) begin
                  ctrl.load_read = 1'b1;
                  state_in       = ST_FLUSH;
               end else if (req_cmd == CMD_SCAN) begin
                  ctrl.start_scan = 1'b1;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = status.pend_valid ? ST_FLUSH : ST_IDLE;
            end else if (!(status.diff && status.pend_valid && !status.out_free)) begin
               ctrl.step     = 1'b1;
               ctrl.emit_mid = status.diff && status.pend_valid;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               ctrl.emit_final = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/sdse_dp.sv =====
`default_nettype none
module sdse_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sdse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdse_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [sdse_pkg::CMD_W-1:0]        req_cmd,
   input  logic [sdse_pkg::INDEX_W-1:0]      req_index,
   input  logic [sdse_pkg::CODE_W-1:0]       req_position_code,
   input  logic [sdse_pkg::BYTE_W-1:0]       req_data_byte,
   input  sdse_pkg::ctrl_cmd_type            ctrl,
   input  logic                              rsp_ready,
   output sdse_pkg::dp_status_type           status,
   output logic                              rsp_valid,
   output logic                              rsp_kind,
   output logic [sdse_pkg::POS_W-1:0]        rsp_pair_position,
   output logic [sdse_pkg::BYTE_W-1:0]       rsp_pair_value,
   output logic [sdse_pkg::NODE_W-1:0]       rsp_node,
   output logic                              rsp_message_end,
   output logic                              rsp_last
);
   import sdse_pkg::*;

   logic [BYTE_W-1:0] app_ff    [STORE_DEPTH];
   logic [BYTE_W-1:0] app_in    [STORE_DEPTH];
   logic [BYTE_W-1:0] shadow_ff [STORE_DEPTH];
   logic [BYTE_W-1:0] shadow_in [STORE_DEPTH];

   logic [ACT_W-1:0]  active_length_ff;
   logic [NODE_W-1:0] dest_node_ff;

   logic [CNT_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  ptr_in;
   logic [RES_W-1:0]  nres_ff;
   logic [RES_W-1:0]  nres_in;
   logic [PAIR_W-1:0] pim_ff;
   logic [PAIR_W-1:0] pim_in;

   logic              pend_valid_ff;
   logic              pend_valid_in;
   logic              pend_kind_ff;
   logic              pend_kind_in;
   logic [POS_W-1:0]  pend_pos_ff;
   logic [POS_W-1:0]  pend_pos_in;
   logic [BYTE_W-1:0] pend_val_ff;
   logic [BYTE_W-1:0] pend_val_in;
   logic [NODE_W-1:0] pend_node_ff;
   logic [NODE_W-1:0] pend_node_in;
   logic              pend_mend_ff;
   logic              pend_mend_in;

   logic              out_valid_ff;
   logic              out_kind_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic [BYTE_W-1:0] out_val_ff;
   logic [NODE_W-1:0] out_node_ff;
   logic              out_mend_ff;
   logic              out_last_ff;

   logic [EFF_W-1:0]  eff_len;
   logic [ADDR_W-1:0] ptr_addr;
   logic [BYTE_W-1:0] app_cur;
   logic              diff;
   logic              scan_done;
   logic              idx_ok;
   logic              code_ok;
   logic [ADDR_W-1:0] idx_addr;
   logic [ADDR_W-1:0] code_addr;
   logic [BYTE_W-1:0] read_byte;
   logic [POS_W-1:0]  pos_now;
   logic [PAIR_W-1:0] pim_inc;
   logic              mend_now;
   logic              emit;

   assign eff_len = (EFF_W'(active_length_ff) > EFF_W'(STORE_DEPTH))
                  ? EFF_W'(STORE_DEPTH) : EFF_W'(active_length_ff);
   assign ptr_addr  = ADDR_W'(ptr_ff);
   assign app_cur   = app_ff[ptr_addr];
   assign scan_done = (EFF_W'(ptr_ff) >= eff_len) || (nres_ff >= RES_W'(MAX_RESULTS));
   assign diff      = !scan_done && (app_cur != shadow_ff[ptr_addr]);
   assign idx_ok    = CMP_W'(req_index) < CMP_W'(STORE_DEPTH);
   assign idx_addr  = ADDR_W'(req_index);
   assign code_ok   = (req_position_code != '0)
                   && (CMP_W'(req_position_code) <= CMP_W'(eff_len));
   assign code_addr = ADDR_W'(req_position_code - CODE_W'(1));
   assign read_byte = idx_ok ? app_ff[idx_addr] : '0;
   assign pos_now   = POS_W'({1'b0, ptr_ff} + (CNT_W + 1)'(1));
   assign pim_inc   = pim_ff + PAIR_W'(1);
   assign mend_now  = pim_inc >= PAIR_W'(MESSAGE_PAIRS);
   assign emit      = ctrl.emit_mid || ctrl.emit_final;

   assign status.scan_done  = scan_done;
   assign status.diff       = diff;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;

   // store updates
   always_comb begin
      app_in    = app_ff;
      shadow_in = shadow_ff;
      if (ctrl.take) begin
         case (req_cmd)
            CMD_WRITE: begin
               if (idx_ok) begin
                  app_in[idx_addr] = req_data_byte;
               end
            end
            CMD_APPLY: begin
               if (code_ok) begin
                  app_in[code_addr]    = req_data_byte;
                  shadow_in[code_addr] = req_data_byte;
               end
            end
            CMD_RESYNC: begin
               for (int i = 0; i < STORE_DEPTH; i++) begin
                  if (CMP_W'(i) < CMP_W'(eff_len)) begin
                     shadow_in[i] = app_ff[i];
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (ctrl.step && diff) begin
         shadow_in[ptr_addr] = app_cur;
      end
   end

   // scan walk and pending result
   always_comb begin
      ptr_in        = ptr_ff;
      nres_in       = nres_ff;
      pim_in        = pim_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_pos_in   = pend_pos_ff;
      pend_val_in   = pend_val_ff;
      pend_node_in  = pend_node_ff;
      pend_mend_in  = pend_mend_ff;
      if (ctrl.emit_final) begin
         pend_valid_in = 1'b0;
      end
      if (ctrl.start_scan) begin
         ptr_in  = '0;
         nres_in = '0;
         pim_in  = '0;
      end
      if (ctrl.load_read) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = KIND_READ;
         pend_pos_in   = '0;
         pend_val_in   = read_byte;
         pend_node_in  = '0;
         pend_mend_in  = 1'b0;
      end
      if (ctrl.step) begin
         ptr_in = ptr_ff + CNT_W'(1);
         if (diff) begin
            nres_in       = nres_ff + RES_W'(1);
            pim_in        = mend_now ? '0 : pim_inc;
            pend_valid_in = 1'b1;
            pend_kind_in  = KIND_PAIR;
            pend_pos_in   = pos_now;
            pend_val_in   = app_cur;
            pend_node_in  = dest_node_ff;
            pend_mend_in  = mend_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            app_ff[i]    <= '0;
            shadow_ff[i] <= '0;
         end
         active_length_ff <= '0;
         dest_node_ff     <= '0;
         ptr_ff           <= '0;
         nres_ff          <= '0;
         pim_ff           <= '0;
         pend_valid_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         app_ff        <= app_in;
         shadow_ff     <= shadow_in;
         ptr_ff        <= ptr_in;
         nres_ff       <= nres_in;
         pim_ff        <= pim_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_ACTIVE_LENGTH: active_length_ff <= ACT_W'(csr_wdata);
               REG_DEST_NODE:     dest_node_ff     <= NODE_W'(csr_wdata);
               default: begin
               end
            endcase
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_pos_ff  <= pend_pos_in;
      pend_val_ff  <= pend_val_in;
      pend_node_ff <= pend_node_in;
      pend_mend_ff <= pend_mend_in;
      if (emit) begin
         out_kind_ff <= pend_kind_ff;
         out_pos_ff  <= pend_pos_ff;
         out_val_ff  <= pend_val_ff;
         out_node_ff <= pend_node_ff;
         out_mend_ff <= pend_mend_ff || (ctrl.emit_final && (pend_kind_ff == KIND_PAIR));
         out_last_ff <= ctrl.emit_final;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_pair_position = out_pos_ff;
   assign rsp_pair_value    = out_val_ff;
   assign rsp_node          = out_node_ff;
   assign rsp_message_end   = out_mend_ff;
   assign rsp_last          = out_last_ff;

endmodule
`default_nettype wire

// ===== sv/shadow_delta_sync_engine_core.sv =====
// Shadow delta synchronization engine: an application byte store and its shadow copy.
// req_ch takes commands (app write, app read, scan, apply received pair, resync);
// rsp_ch returns read data and delta pairs, each with a last flag on the final result
// of its command and message_end on the final pair of every outgoing message.
// csr_we/csr_index/csr_wdata set active_length and dest_node; the user must write them
// only while the block is idle; the block does not enforce this. Write, apply, resync
// and unknown commands finish in the accept cycle (resync copies every active entry at
// once). A read's result goes from the pending register to the output register once
// that is free. A scan compares one entry per cycle unless a pair waits on a busy
// output register; each pair stays pending until the next, so the last is flagged.
// A new command is accepted only in the idle state; a result may still wait in the
// output register meanwhile. When the receiver stalls, a scan halts at the next changed
// entry until the output register frees, and no result is lost.
// Synchronous reset clears both stores, the registers and all control state at once.
`default_nettype none
module shadow_delta_sync_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   sdse_req_if.sink                          req_ch,
   sdse_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [sdse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdse_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sdse_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type dp_status;
   logic          req_ready;

   assign req_ch.ready = req_ready;

   sdse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .status    (dp_status),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   sdse_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_cmd           (req_ch.cmd),
      .req_index         (req_ch.index),
      .req_position_code (req_ch.position_code),
      .req_data_byte     (req_ch.data_byte),
      .ctrl              (ctrl),
      .rsp_ready         (rsp_ch.ready),
      .status            (dp_status),
      .rsp_valid         (rsp_ch.valid),
      .rsp_kind          (rsp_ch.kind),
      .rsp_pair_position (rsp_ch.pair_position),
      .rsp_pair_value    (rsp_ch.pair_value),
      .rsp_node          (rsp_ch.node),
      .rsp_message_end   (rsp_ch.message_end),
      .rsp_last          (rsp_ch.last)
   );

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !dp_status.pend_valid)
      else $error("pending result left over when idle");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit_mid || ctrl.emit_final) |-> dp_status.out_free)
      else $error("result overwrote a waiting transaction");

   a_last_ends_message: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == KIND_PAIR && rsp_ch.last) |-> rsp_ch.message_end)
      else $error("final pair without message end");

   a_read_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == KIND_READ) |-> (rsp_ch.last && !rsp_ch.message_end))
      else $error("read transaction malformed");

endmodule
`default_nettype wire

// ===== test/shadow_delta_sync_engine_core_tb.sv =====
`default_nettype none
module shadow_delta_sync_engine_core_tb;
   import sdse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_PERCENT   = 10;
   localparam int TOTAL_ITEMS    = 280;
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] index;
      logic [CODE_W-1:0]  position_code;
      logic [BYTE_W-1:0]  data_byte;
   } sync_cmd_type;

   typedef struct packed {
      logic              kind;
      logic [POS_W-1:0]  pair_position;
      logic [BYTE_W-1:0] pair_value;
      logic [NODE_W-1:0] node;
      logic              message_end;
      logic              last;
   } delta_result_type;

   typedef enum logic [1:0] {STEP_ITEM, STEP_DRAIN, STEP_CSR, STEP_HOLD} step_op_type;

   typedef struct packed {
      step_op_type             op;
      sync_cmd_type            item;
      logic [CSR_IDX_W-1:0]    reg_index;
      logic [CSR_DATA_W-1:0]   reg_value;
   } sync_step_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sdse_req_if req_ch ();
   sdse_rsp_if rsp_ch ();

   shadow_delta_sync_engine_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model of the block
   logic [BYTE_W-1:0] app_model    [STORE_DEPTH];
   logic [BYTE_W-1:0] shadow_model [STORE_DEPTH];
   logic [ACT_W-1:0]  model_len;
   logic [NODE_W-1:0] model_node;

   sync_step_type    step_queue [$];
   delta_result_type expected_results [$];

   int  cycle_count = 0;
   int  items_accepted = 0;
   int  items_queued = 0;
   int  error_count = 0;
   int  settle_left = 0;
   int  hold_left = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   bit  req_fire = 1'b0;
   bit  calm;

   assign calm = (items_accepted >= 120) && (items_accepted < 180);

   always #4 clock = ~clock;

   task automatic predict_command(input sync_cmd_type it);
      delta_result_type r;
      delta_result_type scan_out [$];
      int eff;
      int pair_count;
      int i;
      begin
         eff = (model_len > STORE_DEPTH) ? STORE_DEPTH : int'(model_len);
         r = '0;
         case (it.cmd)
            CMD_WRITE: app_model[it.index] = it.data_byte;
            CMD_READ: begin
               r.kind = KIND_READ;
               r.pair_value = app_model[it.index];
               r.last = 1'b1;
               expected_results.push_back(r);
            end
            CMD_SCAN: begin
               pair_count = 0;
               for (i = 0; i < eff && scan_out.size() < MAX_RESULTS; i++) begin
                  if (app_model[i] != shadow_model[i]) begin
                     shadow_model[i] = app_model[i];
                     pair_count++;
                     r = '0;
                     r.kind = KIND_PAIR;
                     r.pair_position = POS_W'(i + 1);
                     r.pair_value = app_model[i];
                     r.node = model_node;
                     r.message_end = (pair_count >= MESSAGE_PAIRS);
                     if (r.message_end) pair_count = 0;
                     scan_out.push_back(r);
                  end
               end
               if (scan_out.size() > 0) begin
                  r = scan_out.pop_back();
                  r.message_end = 1'b1;
                  r.last = 1'b1;
                  scan_out.push_back(r);
               end
               foreach (scan_out[k]) expected_results.push_back(scan_out[k]);
            end
            CMD_APPLY: begin
               if (it.position_code != 0 && int'(it.position_code) <= eff) begin
                  app_model[int'(it.position_code) - 1] = it.data_byte;
                  shadow_model[int'(it.position_code) - 1] = it.data_byte;
               end
            end
            CMD_RESYNC: begin
               for (i = 0; i < eff; i++) shadow_model[i] = app_model[i];
            end
            default: ;
         endcase
      end
   endtask

   // monitor: sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      delta_result_type got;
      delta_result_type want;
      sync_cmd_type     seen;
      cycle_count <= cycle_count + 1;
      req_fire = 1'b0;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == REG_ACTIVE_LENGTH) model_len = csr_wdata[ACT_W-1:0];
            else if (csr_index == REG_DEST_NODE) model_node = csr_wdata[NODE_W-1:0];
         end
         if (req_ch.valid && req_ch.ready) begin
            req_fire = 1'b1;
            seen.cmd = req_ch.cmd;
            seen.index = req_ch.index;
            seen.position_code = req_ch.position_code;
            seen.data_byte = req_ch.data_byte;
            predict_command(seen);
            items_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind = rsp_ch.kind;
            got.pair_position = rsp_ch.pair_position;
            got.pair_value = rsp_ch.pair_value;
            got.node = rsp_ch.node;
            got.message_end = rsp_ch.message_end;
            got.last = rsp_ch.last;
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction: kind %0d position %0d value %0d",
                      got.kind, got.pair_position, got.pair_value);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.kind != want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                  error_count++;
               end
               if (got.pair_position != want.pair_position) begin
                  $error("pair_position: expected %0d, actual %0d",
                         want.pair_position, got.pair_position);
                  error_count++;
               end
               if (got.pair_value != want.pair_value) begin
                  $error("pair_value: expected %0d, actual %0d",
                         want.pair_value, got.pair_value);
                  error_count++;
               end
               if (got.node != want.node) begin
                  $error("node: expected %0d, actual %0d", want.node, got.node);
                  error_count++;
               end
               if (got.message_end != want.message_end) begin
                  $error("message_end: expected %0d, actual %0d",
                         want.message_end, got.message_end);
                  error_count++;
               end
               if (got.last != want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   // driver: request channel and register port, changed at the falling edge
   always @(negedge clock) begin
      logic          next_valid;
      logic          next_we;
      sync_step_type s;
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         next_valid = req_ch.valid;
         next_we = 1'b0;
         if (req_fire) next_valid = 1'b0;
         if (!next_valid) begin
            if (settle_left > 0) begin
               settle_left--;
            end else if (step_queue.size() > 0) begin
               s = step_queue[0];
               case (s.op)
                  STEP_ITEM: begin
                     if (calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
                        void'(step_queue.pop_front());
                        req_ch.cmd <= s.item.cmd;
                        req_ch.index <= s.item.index;
                        req_ch.position_code <= s.item.position_code;
                        req_ch.data_byte <= s.item.data_byte;
                        next_valid = 1'b1;
                     end
                  end
                  STEP_DRAIN: begin
                     if (expected_results.size() == 0) begin
                        void'(step_queue.pop_front());
                        settle_left = SETTLE_CYCLES;
                     end
                  end
                  STEP_CSR: begin
                     void'(step_queue.pop_front());
                     next_we = 1'b1;
                     csr_index <= s.reg_index;
                     csr_wdata <= s.reg_value;
                  end
                  default: begin
                     void'(step_queue.pop_front());
                     hold_requests <= hold_requests + 1;
                  end
               endcase
            end
         end
         req_ch.valid <= next_valid;
         csr_we <= next_we;
      end
   end

   // receiver: ready changed at the falling edge, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   task automatic add_item(input logic [CMD_W-1:0] cmd, input int index, input int code,
                           input int data);
      sync_step_type s;
      begin
         s = '0;
         s.op = STEP_ITEM;
         s.item.cmd = cmd;
         s.item.index = INDEX_W'(index);
         s.item.position_code = CODE_W'(code);
         s.item.data_byte = BYTE_W'(data);
         step_queue.push_back(s);
         items_queued++;
      end
   endtask

   task automatic add_marker(input step_op_type op);
      sync_step_type s;
      begin
         s = '0;
         s.op = op;
         step_queue.push_back(s);
      end
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      sync_step_type s;
      begin
         s = '0;
         s.op = STEP_CSR;
         s.reg_index = idx;
         s.reg_value = CSR_DATA_W'(value);
         step_queue.push_back(s);
      end
   endtask

   function automatic int pick_index(input int eff);
      if (eff > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, eff - 1);
      return $urandom_range(0, 31);
   endfunction

   task automatic add_sequence(input int eff);
      int r;
      int k;
      int i;
      begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            for (i = 0; i < STORE_DEPTH; i++) add_item(CMD_WRITE, i, $urandom, $urandom);
            add_item(CMD_SCAN, $urandom, $urandom, $urandom);
         end else if (r < 55) begin
            k = $urandom_range(1, 6);
            for (i = 0; i < k; i++) add_item(CMD_WRITE, pick_index(eff), $urandom, $urandom);
            add_item(CMD_SCAN, $urandom, $urandom, $urandom);
         end else if (r < 65) begin
            k = $urandom_range(1, 3);
            for (i = 0; i < k; i++) add_item(CMD_READ, pick_index(eff), $urandom, $urandom);
         end else if (r < 75) begin
            if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 255);
            else k = $urandom_range(0, eff + 1);
            add_item(CMD_APPLY, $urandom, k, $urandom);
            if ($urandom_range(0, 1) == 0) add_item(CMD_SCAN, $urandom, $urandom, $urandom);
            else add_item(CMD_READ, (k > 0) ? k - 1 : 0, $urandom, $urandom);
         end else if (r < 82) begin
            add_item(CMD_WRITE, pick_index(eff), $urandom, $urandom);
            add_item(CMD_RESYNC, $urandom, $urandom, $urandom);
            add_item(CMD_SCAN, $urandom, $urandom, $urandom);
         end else begin
            k = $urandom_range(1, 3);
            for (i = 0; i < k; i++)
               add_item(CMD_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
         end
      end
   endtask

   function automatic int pick_length();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return 16;
         3: return 17;
         4: return 32;
         5: return 33;
         6: return 63;
         default: return $urandom_range(0, 63);
      endcase
   endfunction

   // timeout
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      int phase;
      int len;
      int eff;
      int i;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.index = '0;
      req_ch.position_code = '0;
      req_ch.data_byte = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (i = 0; i < STORE_DEPTH; i++) begin
         app_model[i] = '0;
         shadow_model[i] = '0;
      end
      model_len = '0;
      model_node = '0;

      // directed part
      add_marker(STEP_DRAIN);
      add_csr(REG_ACTIVE_LENGTH, 32);
      add_csr(REG_DEST_NODE, 16'hFFFF);
      add_item(CMD_WRITE, 0, 0, 8'hFF);
      add_item(CMD_WRITE, 31, 8'hFF, 8'h80);
      add_item(CMD_WRITE, 5, 0, 8'h55);
      add_item(CMD_READ, 0, 0, 0);
      add_item(CMD_READ, 31, 0, 8'hFF);
      add_item(CMD_READ, 7, 0, 0);
      add_item(CMD_SCAN, 0, 0, 0);
      add_item(CMD_SCAN, 31, 8'hFF, 8'hFF);
      add_item(CMD_APPLY, 0, 0, 8'h11);
      add_item(CMD_APPLY, 0, 32, 8'hAA);
      add_item(CMD_APPLY, 0, 33, 8'hBB);
      add_item(CMD_APPLY, 0, 255, 8'hCC);
      add_item(CMD_READ, 31, 0, 0);
      add_item(CMD_WRITE, 3, 0, 8'h7E);
      add_item(CMD_RESYNC, 0, 0, 0);
      add_item(CMD_SCAN, 0, 0, 0);
      for (i = CMD_SPARE_FIRST; i <= CMD_SPARE_LAST; i++)
         add_item(CMD_W'(i), $urandom, $urandom, $urandom);
      add_item(CMD_READ, 3, 0, 0);
      // length beyond depth, stray upper bits in the write data
      add_marker(STEP_DRAIN);
      add_csr(REG_ACTIVE_LENGTH, 16'hFFE4);
      add_csr(REG_DEST_NODE, 0);
      add_item(CMD_WRITE, 31, 0, 8'h01);
      add_item(CMD_SCAN, 0, 0, 0);
      // zero length
      add_marker(STEP_DRAIN);
      add_csr(REG_ACTIVE_LENGTH, 0);
      add_item(CMD_WRITE, 0, 0, 8'h33);
      add_item(CMD_SCAN, 0, 0, 0);
      add_item(CMD_APPLY, 0, 1, 8'h44);
      add_item(CMD_READ, 0, 0, 0);
      add_marker(STEP_DRAIN);
      add_csr(REG_ACTIVE_LENGTH, 1);
      add_item(CMD_SCAN, 0, 0, 0);

      // random part
      phase = 0;
      while (items_queued < TOTAL_ITEMS) begin
         phase++;
         len = (phase == 1) ? 32 : pick_length();
         eff = (len > STORE_DEPTH) ? STORE_DEPTH : len;
         add_marker(STEP_DRAIN);
         add_csr(REG_ACTIVE_LENGTH, len);
         add_csr(REG_DEST_NODE, $urandom_range(0, 65535));
         if (phase == 1) begin
            // receiver holds off while a full scan and reads back up behind it
            add_marker(STEP_HOLD);
            for (i = 0; i < STORE_DEPTH; i++) add_item(CMD_WRITE, i, $urandom, $urandom);
            add_item(CMD_SCAN, $urandom, $urandom, $urandom);
            for (i = 0; i < 4; i++) add_item(CMD_READ, $urandom, $urandom, $urandom);
            add_item(CMD_SCAN, $urandom, $urandom, $urandom);
            add_marker(STEP_DRAIN);
         end
         for (i = 0; i < 12 && items_queued < TOTAL_ITEMS; i++) add_sequence(eff);
      end
      add_marker(STEP_DRAIN);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (step_queue.size() == 0 && req_ch.valid == 1'b0 && expected_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
sv/sdse_pkg.sv
sv/sdse_if.sv
sv/sdse_ctrl.sv
sv/sdse_dp.sv
sv/shadow_delta_sync_engine_core.sv
test/shadow_delta_sync_engine_core_tb.sv
